[rtl/pma_pkg.sv]
// Package for the pitch moving average block: default sizes, register widths
// and the reset value of the window register. No dependencies.
package pma_pkg;

   localparam int MAX_WINDOW_DEFAULT   = 64;
   localparam int SAMPLE_WIDTH_DEFAULT = 16;

   // Width of the window register and of the samples_used field.
   localparam int WINDOW_W = 7;
   localparam int USED_W   = 7;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(10);

endpackage

[rtl/pitch_moving_average.sv]
// Top level of the pitch moving average: front end, two-entry queue and
// serial divider. Depends on pma_pkg, pma_front, pma_queue and pma_divider.
//
//   channel  direction  fields (lowest bit first)
//   req_     in         tdata: pitch_sample
//   rsp_     out        tdata: average_pitch, samples_used, zero fill
//   csr_     in         wdata: window_length
//
// A request passes the front end through accept, ring read and update; the
// serial divider then works through the SUM_W bits of the sum (SAMPLE_WIDTH
// plus log2 of MAX_WINDOW), takes a new request only once it is done with the
// last one and sets the rate. Reset is synchronous, clears the sum, fill count
// and pointer and sets the window register to ten; the ring is not cleared.
// The queue and the response register let either side stall on its own.
module pitch_moving_average #(
   parameter int MAX_WINDOW   = pma_pkg::MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_WIDTH = pma_pkg::SAMPLE_WIDTH_DEFAULT,
   localparam int REQ_W       = ((SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int RSP_W       = ((SAMPLE_WIDTH + pma_pkg::USED_W + 7) / 8) * 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_W-1:0]             req_tdata,  // pitch_sample
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_W-1:0]             rsp_tdata,  // average_pitch, samples_used
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pma_pkg::WINDOW_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
   localparam int Q_W   = SUM_W + CNT_W;

   logic                    push_valid;
   logic [SUM_W-1:0]        push_sum;
   logic [CNT_W-1:0]        push_count;
   logic                    queue_full;
   logic                    pop_valid;
   logic                    pop_ready;
   logic [Q_W-1:0]          pop_data;
   logic [SAMPLE_WIDTH-1:0] average_pitch;
   logic [CNT_W-1:0]        used_count;

   assign csr_ready = 1'b1;

   pma_front #(
      .MAX_WINDOW   (MAX_WINDOW),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_sample (req_tdata[SAMPLE_WIDTH-1:0]),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_sum   (push_sum),
      .push_count (push_count)
   );

   pma_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_count, push_sum}),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   pma_divider #(
      .MAX_WINDOW   (MAX_WINDOW),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pop_valid),
      .in_ready    (pop_ready),
      .in_sum      (pop_data[SUM_W-1:0]),
      .in_count    (pop_data[Q_W-1:SUM_W]),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_average (average_pitch),
      .out_used    (used_count)
   );

   assign rsp_tdata = RSP_W'({pma_pkg::USED_W'(used_count), average_pitch});

endmodule

[rtl/pma_front.sv]
// Front end of the pitch moving average: accepts requests, keeps the sample
// ring, running sum, fill count and window register, and pushes {count, sum}.
// Depends on pma_pkg.
module pma_front #(
   parameter int MAX_WINDOW   = pma_pkg::MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_WIDTH = pma_pkg::SAMPLE_WIDTH_DEFAULT,
   localparam int PTR_W       = $clog2(MAX_WINDOW),
   localparam int CNT_W       = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W       = SAMPLE_WIDTH + $clog2(MAX_WINDOW)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [SAMPLE_WIDTH-1:0]      req_sample,
   input  logic                         csr_valid,
   input  logic [pma_pkg::WINDOW_W-1:0] csr_wdata,
   input  logic                         queue_full,
   output logic                         push_valid,
   output logic [SUM_W-1:0]             push_sum,
   output logic [CNT_W-1:0]             push_count
);

   localparam int ADDR_SUM_W = $clog2(2 * MAX_WINDOW);
   localparam int EXT_W      = (CNT_W + 1 > pma_pkg::WINDOW_W) ? CNT_W + 1 : pma_pkg::WINDOW_W;
   localparam int EXT_BITS   = SUM_W - SAMPLE_WIDTH;

   typedef enum logic [1:0] {IDLE, READ, UPDATE} state_type;

   state_type                      state_ff;
   logic [pma_pkg::WINDOW_W-1:0]   window_ff;
   logic [SAMPLE_WIDTH-1:0]        sample_ff;
   logic [SAMPLE_WIDTH-1:0]        oldest_ff;
   logic [SUM_W-1:0]               sum_ff;
   logic [SUM_W-1:0]               sum_in;
   logic [CNT_W-1:0]               fill_ff;
   logic [CNT_W-1:0]               fill_in;
   logic [PTR_W-1:0]               wp_ff;
   logic [PTR_W-1:0]               wp_in;
   logic [PTR_W-1:0]               rd_addr;
   logic [ADDR_SUM_W-1:0]          addr_sum;
   logic [EXT_W-1:0]               win_raw;
   logic [EXT_W-1:0]               win_eff;
   logic [EXT_W-1:0]               count_up;
   logic                           retire;
   logic [SUM_W-1:0]               sample_ext;
   logic [SUM_W-1:0]               oldest_ext;
   logic [SAMPLE_WIDTH-1:0]        ring_mem [MAX_WINDOW];

   always_comb begin
      addr_sum = ADDR_SUM_W'(wp_ff) + ADDR_SUM_W'(MAX_WINDOW) - ADDR_SUM_W'(fill_ff);
      if (addr_sum >= ADDR_SUM_W'(MAX_WINDOW)) begin
         addr_sum = addr_sum - ADDR_SUM_W'(MAX_WINDOW);
      end
      rd_addr = addr_sum[PTR_W-1:0];

      win_raw = EXT_W'(window_ff);
      priority if (win_raw == '0) begin
         win_eff = EXT_W'(1);
      end else if (win_raw > EXT_W'(MAX_WINDOW)) begin
         win_eff = EXT_W'(MAX_WINDOW);
      end else begin
         win_eff = win_raw;
      end

      count_up   = EXT_W'(fill_ff) + EXT_W'(1);
      retire     = count_up > win_eff;
      sample_ext = {{EXT_BITS{sample_ff[SAMPLE_WIDTH-1]}}, sample_ff};
      oldest_ext = {{EXT_BITS{oldest_ff[SAMPLE_WIDTH-1]}}, oldest_ff};
      sum_in     = sum_ff + sample_ext - (retire ? oldest_ext : '0);
      fill_in    = retire ? fill_ff : fill_ff + CNT_W'(1);
      wp_in      = (wp_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_ff + PTR_W'(1);
   end

   assign req_ready  = (state_ff == IDLE) && !queue_full;
   assign push_valid = (state_ff == UPDATE);
   assign push_sum   = sum_in;
   assign push_count = fill_in;

   always_ff @(posedge clock) begin
      oldest_ff <= ring_mem[rd_addr];
      if (state_ff == UPDATE) begin
         ring_mem[wp_ff] <= sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         window_ff <= pma_pkg::WINDOW_RESET;
         sum_ff    <= '0;
         fill_ff   <= '0;
         wp_ff     <= '0;
      end else begin
         if (csr_valid) begin
            window_ff <= csr_wdata;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid && req_ready) begin
                  sample_ff <= req_sample;
                  state_ff  <= READ;
               end
            end
            READ: begin
               state_ff <= UPDATE;
            end
            UPDATE: begin
               sum_ff   <= sum_in;
               fill_ff  <= fill_in;
               wp_ff    <= wp_in;
               state_ff <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_WINDOW))
      else $error("fill count above ring depth");

   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == UPDATE) |=> (fill_ff != '0))
      else $error("fill count zero after an update");
`endif

endmodule

[rtl/pma_queue.sv]
// Two-entry queue that decouples the front end from the divider.
// Depends on nothing.
module pma_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

[rtl/pma_divider.sv]
// Back end of the pitch moving average: serial restoring divider of the
// signed sum by the count, truncating toward zero, with the response register.
// Depends on pma_pkg only through the sizes handed down.
module pma_divider #(
   parameter int MAX_WINDOW   = pma_pkg::MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_WIDTH = pma_pkg::SAMPLE_WIDTH_DEFAULT,
   localparam int CNT_W       = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W       = SAMPLE_WIDTH + $clog2(MAX_WINDOW)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [SUM_W-1:0]        in_sum,
   input  logic [CNT_W-1:0]        in_count,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [SAMPLE_WIDTH-1:0] out_average,
   output logic [CNT_W-1:0]        out_used
);

   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [1:0] {IDLE, RUN, FINISH} state_type;

   state_type               state_ff;
   logic                    neg_ff;
   logic [SUM_W-1:0]        quo_ff;
   logic [CNT_W-1:0]        div_ff;
   logic [CNT_W-1:0]        rem_ff;
   logic [STEP_W-1:0]       step_ff;
   logic                    out_valid_ff;
   logic [SAMPLE_WIDTH-1:0] out_average_ff;
   logic [CNT_W-1:0]        out_used_ff;
   logic [CNT_W:0]          trial;
   logic [CNT_W:0]          diff;
   logic                    fits;
   logic [SUM_W-1:0]        result;
   logic                    out_free;

   always_comb begin
      trial    = {rem_ff, quo_ff[SUM_W-1]};
      diff     = trial - {1'b0, div_ff};
      fits     = trial >= {1'b0, div_ff};
      result   = neg_ff ? SUM_W'(0) - quo_ff : quo_ff;
      out_free = !out_valid_ff || out_ready;
   end

   assign in_ready    = (state_ff == IDLE);
   assign out_valid   = out_valid_ff;
   assign out_average = out_average_ff;
   assign out_used    = out_used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == FINISH) && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && out_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (in_valid) begin
                  neg_ff   <= in_sum[SUM_W-1];
                  quo_ff   <= in_sum[SUM_W-1] ? SUM_W'(0) - in_sum : in_sum;
                  div_ff   <= in_count;
                  rem_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= RUN;
               end
            end
            RUN: begin
               rem_ff  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
               quo_ff  <= {quo_ff[SUM_W-2:0], fits};
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  state_ff <= FINISH;
               end
            end
            FINISH: begin
               if (out_free) begin
                  out_average_ff <= result[SAMPLE_WIDTH-1:0];
                  out_used_ff    <= div_ff;
                  state_ff       <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN) |-> (div_ff != '0))
      else $error("divider running with a zero count");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == RUN) |-> (rem_ff < div_ff))
      else $error("partial remainder not below the divisor");
`endif

endmodule

[tb/pitch_average_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the pitch moving average. It watches the request, response
// and window-write channels, predicts each response and compares it. Uses pma_pkg.
module pitch_average_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [15:0]                  req_tdata,  // pitch_sample
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [23:0]                  rsp_tdata,  // average_pitch, samples_used, zero fill
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [pma_pkg::WINDOW_W-1:0] csr_wdata,
   output int                           mismatch_count,
   output int                           awaiting_count
);
   localparam int RING_DEPTH = pma_pkg::MAX_WINDOW_DEFAULT;
   localparam int SAMPLE_W   = pma_pkg::SAMPLE_WIDTH_DEFAULT;
   localparam int PTR_W      = $clog2(RING_DEPTH);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]   average_pitch;
      logic [pma_pkg::USED_W-1:0]   samples_used;
   } pitch_average_type;

   logic signed [SAMPLE_W-1:0]   sample_ring [RING_DEPTH];
   int                           held_sum;
   int                           held_count;
   logic [PTR_W-1:0]             write_slot;
   logic [pma_pkg::WINDOW_W-1:0] window_reg;
   pitch_average_type            expected_averages [$];
   int                           errors = 0;

   function automatic pitch_average_type boxcar_average(logic signed [SAMPLE_W-1:0] sample);
      int                         span;
      logic [PTR_W-1:0]           oldest_slot;
      logic signed [SAMPLE_W-1:0] oldest;
      pitch_average_type          average;
      if (window_reg == 0) begin
         span = 1;
      end else if (window_reg > RING_DEPTH) begin
         span = RING_DEPTH;
      end else begin
         span = int'(window_reg);
      end
      // The oldest held sample is read before the new one may overwrite its slot.
      oldest_slot = write_slot - PTR_W'(held_count);
      oldest = sample_ring[oldest_slot];
      sample_ring[write_slot] = sample;
      held_sum += sample;
      held_count++;
      if (held_count > span) begin
         held_sum -= oldest;
         held_count--;
      end
      write_slot++;
      average.average_pitch = SAMPLE_W'(held_sum / held_count);
      average.samples_used  = pma_pkg::USED_W'(held_count);
      return average;
   endfunction

   always @(posedge clock) begin
      pitch_average_type predicted;
      pitch_average_type observed;
      if (reset) begin
         expected_averages.delete();
         held_sum   = 0;
         held_count = 0;
         write_slot = '0;
         window_reg = pma_pkg::WINDOW_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            window_reg = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            expected_averages.push_back(boxcar_average(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            observed.average_pitch = rsp_tdata[SAMPLE_W-1:0];
            observed.samples_used  = rsp_tdata[SAMPLE_W +: pma_pkg::USED_W];
            if (expected_averages.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("%0t: response with no request pending: average %0d, used %0d",
                           $realtime, observed.average_pitch, observed.samples_used);
               end
            end else begin
               predicted = expected_averages.pop_front();
               if (observed.average_pitch !== predicted.average_pitch ||
                   observed.samples_used !== predicted.samples_used) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: average expected %0d got %0d, used expected %0d got %0d",
                              $realtime, predicted.average_pitch, observed.average_pitch,
                              predicted.samples_used, observed.samples_used);
                  end
               end
            end
         end
      end
      mismatch_count <= errors;
      awaiting_count <= expected_averages.size();
   end

endmodule

[tb/pitch_moving_average_tb.sv]
`timescale 1ns / 100ps
// Top of the pitch moving average testbench: clock, reset, request and window
// stimulus, response stalls and the verdict. Uses pma_pkg and pitch_average_checker.
module pitch_moving_average_tb;

   localparam int OPENING_PHASES = 4;
   localparam logic [pma_pkg::WINDOW_W-1:0] OPENING_WINDOW [OPENING_PHASES] = '{0, 1, 2, 10};
   localparam int OPENING_ITEMS [OPENING_PHASES] = '{5, 2, 3, 12};
   localparam logic [15:0] OPENING_PITCH [22] = '{
      16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001,
      16'h7FFF, 16'h8000,
      16'h7FFF, 16'h7FFF, 16'h8000,
      16'h8000, 16'h8000, 16'h8000, 16'h5555, 16'hAAAA, 16'hFFFD,
      16'h0003, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0007, 16'hFFF9
   };

   localparam int PHASES = 11;
   localparam logic [pma_pkg::WINDOW_W-1:0] PHASE_WINDOW [PHASES] =
      '{10, 5, 37, 20, 64, 127, 3, 100, 0, 1, 64};
   localparam int PHASE_ITEMS [PHASES] = '{40, 40, 60, 50, 100, 80, 80, 60, 60, 40, 320};
   localparam int PHASE_LEAN [PHASES]  = '{0, 0, 1, 0, -1, 1, 0, 0, 0, 0, 0};

   logic                         clock;
   logic                         reset;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [15:0]                  req_tdata;   // pitch_sample
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [23:0]                  rsp_tdata;   // average_pitch, samples_used, zero fill
   logic                         csr_valid;
   logic                         csr_ready;
   logic [pma_pkg::WINDOW_W-1:0] csr_wdata;
   int                           mismatch_count;
   int                           awaiting_count;
   bit                           req_steady = 1'b0;
   bit                           rsp_steady = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   pitch_moving_average dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   pitch_average_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .awaiting_count (awaiting_count)
   );

   function automatic int idle_cycles(bit steady);
      return steady ? 0 : $urandom_range(0, 10);
   endfunction

   // A nonzero lean pushes most samples to full scale so the sum reaches its extremes.
   function automatic logic [15:0] pitch_value(int lean);
      logic [15:0] pitch;
      if (lean != 0 && $urandom_range(0, 3) != 0) begin
         pitch = (lean > 0) ? 16'h7FFF : 16'h8000;
      end else begin
         case ($urandom_range(0, 9))
            0: pitch = 16'h7FFF;
            1: pitch = 16'h8000;
            2: pitch = 16'($urandom_range(0, 16)) - 16'd8;
            default: pitch = 16'($urandom);
         endcase
      end
      return pitch;
   endfunction

   task automatic send_pitch(logic [15:0] sample);
      int gap;
      if ($urandom_range(0, 15) == 0) begin
         req_steady = !req_steady;
      end
      gap = idle_cycles(req_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      do @(posedge clock); while (!req_tready);
   endtask

   // The window is only changed once every pending request has been answered.
   task automatic write_window(logic [pma_pkg::WINDOW_W-1:0] length);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= length;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            rsp_steady = !rsp_steady;
         end
         stall = idle_cycles(rsp_steady);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin
      int pick;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_wdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      pick = 0;
      for (int p = 0; p < OPENING_PHASES; p++) begin
         write_window(OPENING_WINDOW[p]);
         for (int n = 0; n < OPENING_ITEMS[p]; n++) begin
            send_pitch(OPENING_PITCH[pick]);
            pick++;
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         write_window(PHASE_WINDOW[p]);
         for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
            send_pitch(pitch_value(PHASE_LEAN[p]));
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && awaiting_count == 0) begin
         $display("PASS pitch_moving_average");
      end else begin
         $display("FAIL pitch_moving_average");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL pitch_moving_average");
      $finish;
   end

endmodule

[files.f]
rtl/pma_pkg.sv
rtl/pma_front.sv
rtl/pma_queue.sv
rtl/pma_divider.sv
rtl/pitch_moving_average.sv
tb/pitch_average_checker.sv
tb/pitch_moving_average_tb.sv
